// ----- rtl/core/gbcc_pkg.sv -----
// Shared types and byte-range constants for the GB18030 character counter.
`timescale 1ns / 1ps

package gbcc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OUT_W  = 16;

    // Byte ranges of the GB18030 code structure
    localparam logic [BYTE_W-1:0] ASCII_HI = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_LO  = 8'h81;
    localparam logic [BYTE_W-1:0] LEAD_HI  = 8'hFE;
    localparam logic [BYTE_W-1:0] TRAIL_LO = 8'h40;
    localparam logic [BYTE_W-1:0] DIGIT_LO = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_HI = 8'h39;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2,
        PH_FOURTH = 2'd3
    } phase_t;

    // Per-byte decode result handed from the classifier to the counters
    typedef struct packed {
        phase_t phase_next;
        logic   third_ok_next;
        logic   ascii_inc;
        logic   double_inc;
        logic   four_inc;
        logic   error_inc;
    } cls_t;

endpackage

// ----- rtl/core/gbcc_stream_if.sv -----
// Valid/ready channel interfaces for the byte input and the count result.
`timescale 1ns / 1ps

interface gbcc_byte_if;
    logic                           valid;
    logic                           ready;
    logic [gbcc_pkg::BYTE_W-1:0]    byte_value;
    logic                           last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface gbcc_count_if;
    logic                           valid;
    logic                           ready;
    logic [gbcc_pkg::OUT_W-1:0]     ascii_count;
    logic [gbcc_pkg::OUT_W-1:0]     double_byte_count;
    logic [gbcc_pkg::OUT_W-1:0]     four_byte_count;
    logic [gbcc_pkg::OUT_W-1:0]     display_width;
    logic [gbcc_pkg::OUT_W-1:0]     error_count;

    modport source (output valid, output ascii_count, output double_byte_count,
                    output four_byte_count, output display_width, output error_count,
                    input ready);
    modport sink   (input valid, input ascii_count, input double_byte_count,
                    input four_byte_count, input display_width, input error_count,
                    output ready);
endinterface

// ----- rtl/core/gbcc_classify.sv -----
// Combinational GB18030 sequence decoder: next phase and count increments per byte.
`timescale 1ns / 1ps

module gbcc_classify
(
    input  gbcc_pkg::phase_t            phase,
    input  logic                        third_ok,
    input  logic [gbcc_pkg::BYTE_W-1:0] byte_value,
    input  logic                        last_byte,
    output gbcc_pkg::cls_t              cls
);

    logic is_lead;
    logic is_trail;
    logic is_digit;
    gbcc_pkg::phase_t phase_next;
    logic third_ok_next;

    assign is_lead  = byte_value inside {[gbcc_pkg::LEAD_LO : gbcc_pkg::LEAD_HI]};
    assign is_trail = byte_value inside {[gbcc_pkg::TRAIL_LO : gbcc_pkg::LEAD_HI]};
    assign is_digit = byte_value inside {[gbcc_pkg::DIGIT_LO : gbcc_pkg::DIGIT_HI]};

    // Next phase and third-byte flag
    always_comb
    begin
        phase_next    = gbcc_pkg::PH_LEAD;
        third_ok_next = third_ok;
        case (phase)
            gbcc_pkg::PH_LEAD:
            begin
                phase_next = is_lead ? gbcc_pkg::PH_SECOND : gbcc_pkg::PH_LEAD;
            end
            gbcc_pkg::PH_SECOND:
            begin
                if (!is_trail && is_digit)
                begin
                    phase_next = gbcc_pkg::PH_THIRD;
                end
            end
            gbcc_pkg::PH_THIRD:
            begin
                phase_next    = gbcc_pkg::PH_FOURTH;
                third_ok_next = is_lead;
            end
            gbcc_pkg::PH_FOURTH:
            begin
                third_ok_next = 1'b0;
            end
            default:
            begin
                phase_next = gbcc_pkg::PH_LEAD;
            end
        endcase
    end

    // Count increments; a sequence left open by the final byte is one more error
    always_comb
    begin
        cls               = '0;
        cls.phase_next    = phase_next;
        cls.third_ok_next = third_ok_next;
        case (phase)
            gbcc_pkg::PH_LEAD:
            begin
                cls.ascii_inc = (byte_value <= gbcc_pkg::ASCII_HI);
                cls.error_inc = (byte_value > gbcc_pkg::LEAD_HI);
            end
            gbcc_pkg::PH_SECOND:
            begin
                cls.double_inc = is_trail;
                cls.error_inc  = !is_trail && !is_digit;
            end
            gbcc_pkg::PH_THIRD:
            begin
                cls.error_inc = 1'b0;
            end
            gbcc_pkg::PH_FOURTH:
            begin
                cls.four_inc  = third_ok && is_digit;
                cls.error_inc = !(third_ok && is_digit);
            end
            default:
            begin
                cls.error_inc = 1'b0;
            end
        endcase
        if (last_byte && (phase_next != gbcc_pkg::PH_LEAD))
        begin
            cls.error_inc = 1'b1;
        end
    end

endmodule

// ----- rtl/core/gb18030_char_counter.sv -----
// Top level of the GB18030 character counter: input register, decode, counters, result register.
`timescale 1ns / 1ps

// GB18030 character counter.
// Channel "bytes" (sink) carries one raw text byte per transaction, with
// last_byte marking the final byte of a string. Channel "counts" (source)
// carries one transaction per string: ASCII, two-byte and four-byte
// character counts, display width (1 column per ASCII, 2 per wide char)
// and the count of bad or cut-off sequences. All counters saturate at
// their all-ones value; after each result the counters start from zero.
// Throughput: one byte per cycle while no final byte waits on a stalled
// receiver, set by the single decode-and-count step between the input
// register and the counter/result registers. A result is registered: the
// final byte's transaction loads the input register, and the result
// register loads from it once the result register is free.
// Reset clears the sequence state, the counters and both valid flags.
// When the receiver stalls, the held result stays put; bytes that are not
// final keep flowing, and a final byte waits in the input register, holding
// bytes.ready low, until the result register frees up.
module gb18030_char_counter
#(
    parameter int unsigned COUNT_WIDTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    gbcc_byte_if.sink           bytes,
    gbcc_count_if.source        counts
);

    localparam int unsigned CW = COUNT_WIDTH;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    // Input register
    logic                           in_valid_reg;
    logic [gbcc_pkg::BYTE_W-1:0]    byte_reg;
    logic                           last_reg;

    // Sequence state and running counters
    gbcc_pkg::phase_t               phase_reg;
    logic                           third_ok_reg;
    logic [CW-1:0]                  ascii_reg;
    logic [CW-1:0]                  double_reg;
    logic [CW-1:0]                  four_reg;
    logic [CW-1:0]                  width_reg;
    logic [CW-1:0]                  error_reg;

    logic [CW-1:0]                  ascii_next;
    logic [CW-1:0]                  double_next;
    logic [CW-1:0]                  four_next;
    logic [CW-1:0]                  width_next;
    logic [CW-1:0]                  error_next;
    logic [1:0]                     width_inc;

    // Result register
    logic                           out_valid_reg;
    logic [gbcc_pkg::OUT_W-1:0]     ascii_out_reg;
    logic [gbcc_pkg::OUT_W-1:0]     double_out_reg;
    logic [gbcc_pkg::OUT_W-1:0]     four_out_reg;
    logic [gbcc_pkg::OUT_W-1:0]     width_out_reg;
    logic [gbcc_pkg::OUT_W-1:0]     error_out_reg;

    gbcc_pkg::cls_t                 cls;
    logic                           advance;
    logic                           accept;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] v, input logic [1:0] inc);
        logic [CW:0] sum;
        begin
            sum = {1'b0, v} + (CW + 1)'(inc);
            sat_add = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[CW-1:0];
        end
    endfunction

    // A non-final byte never needs the result register; a final one waits
    // until the previous result is gone or leaving this cycle.
    assign advance     = in_valid_reg && (!last_reg || !out_valid_reg || counts.ready);
    assign bytes.ready = !in_valid_reg || advance;
    assign accept      = bytes.valid && bytes.ready;

    gbcc_classify u_classify
    (
        .phase      (phase_reg),
        .third_ok   (third_ok_reg),
        .byte_value (byte_reg),
        .last_byte  (last_reg),
        .cls        (cls)
    );

    always_comb
    begin
        if (cls.ascii_inc)
        begin
            width_inc = 2'd1;
        end
        else if (cls.double_inc || cls.four_inc)
        begin
            width_inc = 2'd2;
        end
        else
        begin
            width_inc = 2'd0;
        end
        ascii_next  = sat_add(ascii_reg,  {1'b0, cls.ascii_inc});
        double_next = sat_add(double_reg, {1'b0, cls.double_inc});
        four_next   = sat_add(four_reg,   {1'b0, cls.four_inc});
        width_next  = sat_add(width_reg,  width_inc);
        error_next  = sat_add(error_reg,  {1'b0, cls.error_inc});
    end

    // Hold the incoming byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= bytes.byte_value;
            last_reg <= bytes.last_byte;
        end
    end

    // Advance sequence state and counters; clear everything after a final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= gbcc_pkg::PH_LEAD;
            third_ok_reg <= 1'b0;
            ascii_reg    <= '0;
            double_reg   <= '0;
            four_reg     <= '0;
            width_reg    <= '0;
            error_reg    <= '0;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                phase_reg    <= gbcc_pkg::PH_LEAD;
                third_ok_reg <= 1'b0;
                ascii_reg    <= '0;
                double_reg   <= '0;
                four_reg     <= '0;
                width_reg    <= '0;
                error_reg    <= '0;
            end
            else
            begin
                phase_reg    <= cls.phase_next;
                third_ok_reg <= cls.third_ok_next;
                ascii_reg    <= ascii_next;
                double_reg   <= double_next;
                four_reg     <= four_next;
                width_reg    <= width_next;
                error_reg    <= error_next;
            end
        end
    end

    // Result register: load on a final byte, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (counts.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            ascii_out_reg  <= gbcc_pkg::OUT_W'(ascii_next);
            double_out_reg <= gbcc_pkg::OUT_W'(double_next);
            four_out_reg   <= gbcc_pkg::OUT_W'(four_next);
            width_out_reg  <= gbcc_pkg::OUT_W'(width_next);
            error_out_reg  <= gbcc_pkg::OUT_W'(error_next);
        end
    end

    assign counts.valid             = out_valid_reg;
    assign counts.ascii_count       = ascii_out_reg;
    assign counts.double_byte_count = double_out_reg;
    assign counts.four_byte_count   = four_out_reg;
    assign counts.display_width     = width_out_reg;
    assign counts.error_count       = error_out_reg;

endmodule

// ----- verif/tb_gb18030_char_counter.sv -----
// Self-checking testbench for the GB18030 character counter.
`timescale 1ns / 1ps

module tb_gb18030_char_counter;

    // Abort when no transaction has moved on either channel for this many cycles.
    localparam int unsigned QUIET_LIMIT  = 4000;
    // Slack after the final drain, in which a stray result would still show.
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef logic [gbcc_pkg::BYTE_W-1:0] byte_t;
    typedef logic [gbcc_pkg::OUT_W-1:0]  cnt_t;

    // One result transaction: the five per-string totals.
    typedef struct packed {
        cnt_t ascii;
        cnt_t dbl;
        cnt_t four;
        cnt_t width;
        cnt_t errors;
    } count_set_t;

    // Shapes of the byte groups that random strings are built from.
    typedef enum int {
        CH_ASCII,
        CH_DOUBLE,
        CH_FOUR,
        CH_LEAD_FF,
        CH_BAD_SECOND,
        CH_BAD_THIRD,
        CH_BAD_FOURTH,
        CH_NOISE
    } char_kind_t;

    logic clk;
    logic rst_n;

    gbcc_byte_if  byte_ch ();
    gbcc_count_if count_ch ();

    gb18030_char_counter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .counts (count_ch)
    );

    // Idle and stall odds, in percent per cycle; the main sequence changes them between phases.
    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned mismatches    = 0;
    int unsigned quiet_cycles  = 0;

    // Predicted decoder state and running totals of the string in progress.
    gbcc_pkg::phase_t seq_phase;
    logic   third_ok;
    cnt_t   ascii_total;
    cnt_t   double_total;
    cnt_t   four_total;
    cnt_t   width_total;
    cnt_t   error_total;

    // Totals of strings whose final byte is accepted but whose result has not arrived yet.
    count_set_t pending_counts[$];

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic cnt_t sat_add(cnt_t v, int unsigned inc);
        logic [gbcc_pkg::OUT_W:0] sum;
        sum = {1'b0, v} + (gbcc_pkg::OUT_W + 1)'(inc);
        return sum[gbcc_pkg::OUT_W] ? '1 : sum[gbcc_pkg::OUT_W-1:0];
    endfunction

    function automatic logic is_digit(byte_t b);
        return (b >= gbcc_pkg::DIGIT_LO) && (b <= gbcc_pkg::DIGIT_HI);
    endfunction

    function automatic void clear_totals();
        seq_phase    = gbcc_pkg::PH_LEAD;
        third_ok     = 1'b0;
        ascii_total  = '0;
        double_total = '0;
        four_total   = '0;
        width_total  = '0;
        error_total  = '0;
    endfunction

    // Advance the predicted decoder by one accepted byte. On the final byte,
    // queue the totals the block owes us and start the next string from zero.
    function automatic void classify_byte(byte_t b, logic last);
        case (seq_phase)
            gbcc_pkg::PH_LEAD:
            begin
                if (b <= gbcc_pkg::ASCII_HI)
                begin
                    ascii_total = sat_add(ascii_total, 1);
                    width_total = sat_add(width_total, 1);
                end
                else if (b <= gbcc_pkg::LEAD_HI)
                    seq_phase = gbcc_pkg::PH_SECOND;
                else
                    error_total = sat_add(error_total, 1);
            end
            gbcc_pkg::PH_SECOND:
            begin
                if (b >= gbcc_pkg::TRAIL_LO && b <= gbcc_pkg::LEAD_HI)
                begin
                    double_total = sat_add(double_total, 1);
                    width_total  = sat_add(width_total, 2);
                    seq_phase    = gbcc_pkg::PH_LEAD;
                end
                else if (is_digit(b))
                    seq_phase = gbcc_pkg::PH_THIRD;
                else
                begin
                    // Bad second byte: drop the pair as one error
                    error_total = sat_add(error_total, 1);
                    seq_phase   = gbcc_pkg::PH_LEAD;
                end
            end
            gbcc_pkg::PH_THIRD:
            begin
                // The verdict on the third byte waits for the fourth
                third_ok  = (b >= gbcc_pkg::LEAD_LO) && (b <= gbcc_pkg::LEAD_HI);
                seq_phase = gbcc_pkg::PH_FOURTH;
            end
            default:
            begin
                if (third_ok && is_digit(b))
                begin
                    four_total  = sat_add(four_total, 1);
                    width_total = sat_add(width_total, 2);
                end
                else
                    error_total = sat_add(error_total, 1);
                third_ok  = 1'b0;
                seq_phase = gbcc_pkg::PH_LEAD;
            end
        endcase

        if (last)
        begin
            // A sequence left open by the final byte costs one more error
            if (seq_phase != gbcc_pkg::PH_LEAD)
                error_total = sat_add(error_total, 1);
            pending_counts.push_back('{ascii_total, double_total, four_total,
                                       width_total, error_total});
            clear_totals();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        // Cap the printout; keep counting regardless
        if (mismatches < 200)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_field(string name, cnt_t got, cnt_t want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Compare each result transaction with the oldest pending totals.
    always @(posedge clk)
    begin
        count_set_t want;
        if (rst_n === 1'b1 && count_ch.valid === 1'b1 && count_ch.ready === 1'b1)
        begin
            if (pending_counts.size() == 0)
                report_mismatch("result transaction with no string pending");
            else
            begin
                want = pending_counts.pop_front();
                check_field("ascii_count",       count_ch.ascii_count,       want.ascii);
                check_field("double_byte_count", count_ch.double_byte_count, want.dbl);
                check_field("four_byte_count",   count_ch.four_byte_count,   want.four);
                check_field("display_width",     count_ch.display_width,     want.width);
                check_field("error_count",       count_ch.error_count,       want.errors);
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
            (count_ch.valid === 1'b1 && count_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("[gb18030_char_counter] ERROR");
                $finish;
            end
        end
    end

    // Receiver: drop ready at random to model a stalling consumer.
    always @(negedge clk)
        count_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic set_idling(int unsigned src_pct, int unsigned snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // Drive one byte from a falling edge and hold it until the block takes it.
    // Valid stays high into the next byte unless the sender idles.
    task automatic send_byte(byte_t b, logic last);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.byte_value <= b;
        byte_ch.last_byte  <= last;
        do
            @(posedge clk);
        while (byte_ch.ready !== 1'b1);
        classify_byte(b, last);
    endtask

    // Send a whole string, marking its final byte.
    task automatic send_string(ref byte_t text[$]);
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    // Hold the sender idle until every pending result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
    endtask

    // Append one random byte group; mostly well-formed characters.
    function automatic void push_char(ref byte_t q[$]);
        char_kind_t kind;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)
            kind = CH_ASCII;
        else if (pick < 55)
            kind = CH_DOUBLE;
        else if (pick < 75)
            kind = CH_FOUR;
        else
            kind = char_kind_t'($urandom_range(CH_NOISE, CH_LEAD_FF));

        case (kind)
            CH_ASCII:
                q.push_back(byte_t'($urandom_range(gbcc_pkg::ASCII_HI, 0)));
            CH_DOUBLE:
            begin
                q.push_back(byte_t'($urandom_range(gbcc_pkg::LEAD_HI, gbcc_pkg::LEAD_LO)));
                q.push_back(byte_t'($urandom_range(gbcc_pkg::LEAD_HI, gbcc_pkg::TRAIL_LO)));
            end
            CH_FOUR:
            begin
                q.push_back(byte_t'($urandom_range(gbcc_pkg::LEAD_HI, gbcc_pkg::LEAD_LO)));
                q.push_back(byte_t'($urandom_range(gbcc_pkg::DIGIT_HI, gbcc_pkg::DIGIT_LO)));
                q.push_back(byte_t'($urandom_range(gbcc_pkg::LEAD_HI, gbcc_pkg::LEAD_LO)));
                q.push_back(byte_t'($urandom_range(gbcc_pkg::DIGIT_HI, gbcc_pkg::DIGIT_LO)));
            end
            CH_LEAD_FF:
                q.push_back(8'hFF);
            CH_BAD_SECOND:
            begin
                q.push_back(byte_t'($urandom_range(gbcc_pkg::LEAD_HI, gbcc_pkg::LEAD_LO)));
                case ($urandom_range(2))
                    0:
                        q.push_back(byte_t'($urandom_range(gbcc_pkg::DIGIT_LO - 1, 0)));
                    1:
                        q.push_back(byte_t'($urandom_range(gbcc_pkg::TRAIL_LO - 1,
                                                           gbcc_pkg::DIGIT_HI + 1)));
                    default:
                        q.push_back(8'hFF);
                endcase
            end
            CH_BAD_THIRD:
            begin
                q.push_back(byte_t'($urandom_range(gbcc_pkg::LEAD_HI, gbcc_pkg::LEAD_LO)));
                q.push_back(byte_t'($urandom_range(gbcc_pkg::DIGIT_HI, gbcc_pkg::DIGIT_LO)));
                q.push_back($urandom_range(1) ? byte_t'(8'hFF)
                                              : byte_t'($urandom_range(gbcc_pkg::ASCII_HI, 0)));
                q.push_back(byte_t'($urandom_range(255)));
            end
            CH_BAD_FOURTH:
            begin
                q.push_back(byte_t'($urandom_range(gbcc_pkg::LEAD_HI, gbcc_pkg::LEAD_LO)));
                q.push_back(byte_t'($urandom_range(gbcc_pkg::DIGIT_HI, gbcc_pkg::DIGIT_LO)));
                q.push_back(byte_t'($urandom_range(gbcc_pkg::LEAD_HI, gbcc_pkg::LEAD_LO)));
                q.push_back($urandom_range(1)
                            ? byte_t'($urandom_range(gbcc_pkg::DIGIT_LO - 1, 0))
                            : byte_t'($urandom_range(255, gbcc_pkg::DIGIT_HI + 1)));
            end
            default:
                q.push_back(byte_t'($urandom_range(255)));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Range edges of each character class, every bad-sequence kind and cut-offs.
    task automatic test_directed();
        byte_t text[$];
        // ASCII and two-byte range edges
        text = '{8'h00, 8'h80, 8'h81, 8'h40, 8'hFE, 8'hFE};
        send_string(text);
        // Four-byte range edges
        text = '{8'h81, 8'h30, 8'h81, 8'h30, 8'hFE, 8'h39, 8'hFE, 8'h39};
        send_string(text);
        // Lone 0xFF lead
        text = '{8'hFF};
        send_string(text);
        // Bad second bytes just outside both ranges, then bad third and fourth
        text = '{8'h81, 8'h3F, 8'hFE, 8'hFF, 8'h81, 8'h30, 8'h80, 8'h30,
                 8'h81, 8'h39, 8'hFE, 8'h3A};
        send_string(text);
        // Strings cut off after the first, second and third byte of a sequence
        text = '{8'h81};
        send_string(text);
        text = '{8'hFE, 8'h39};
        send_string(text);
        text = '{8'h81, 8'h30, 8'hFE};
        send_string(text);
    endtask

    // Strings built from random byte groups, sometimes cut off mid-sequence.
    task automatic test_random_strings(int unsigned byte_budget);
        byte_t       text[$];
        int unsigned sent;
        int unsigned cut;
        sent = 0;
        while (sent < byte_budget)
        begin
            text.delete();
            repeat ($urandom_range(6, 1))
                push_char(text);
            if ($urandom_range(99) < 15)
            begin
                cut  = $urandom_range(text.size() - 1, 0);
                text = text[0:cut];
            end
            send_string(text);
            sent += text.size();
        end
    endtask

    // Let the block drain fully between two batches of random strings, then resume.
    task automatic test_drain_pause();
        test_random_strings(20);
        wait_for_results();
        test_random_strings(20);
    endtask

    initial
    begin
        byte_ch.valid      = 1'b0;
        byte_ch.byte_value = '0;
        byte_ch.last_byte  = 1'b0;
        count_ch.ready     = 1'b0;
        rst_n              = 1'b0;
        clear_totals();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling(0, 0);
        test_directed();

        set_idling(87, 0);
        test_drain_pause();

        // Random phases: free-running, starved sender, stalling receiver, light both
        set_idling(0, 0);
        test_random_strings(215);
        set_idling(87, 0);
        test_random_strings(215);
        set_idling(0, 87);
        test_random_strings(215);
        set_idling(12, 12);
        test_random_strings(215);

        // Drain, then give the block DRAIN_CYCLES of slack to show any stray result
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_counts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_counts.size()));

        if (mismatches == 0)
            $display("[gb18030_char_counter] OK");
        else
            $display("[gb18030_char_counter] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/gbcc_pkg.sv
rtl/core/gbcc_stream_if.sv
rtl/core/gbcc_classify.sv
rtl/core/gb18030_char_counter.sv
verif/tb_gb18030_char_counter.sv
